FILE: src/mss_pkg.sv
// Shared types, constants and helpers for the mode sensitivity statistics block.
`timescale 1ns / 1ps
package mss_pkg;

  localparam int unsigned MAX_MODES  = 1024;
  localparam int unsigned MODE_W     = 10;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned STEP_W     = 7;
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(80);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(32);
  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(48);

  // 2^32 / (16*pi^2), rounded
  localparam logic [47:0] EFF_K = 48'd27198198;

  localparam logic [15:0] AMP_LIMIT_RESET  = 16'd256;
  localparam logic [15:0] WAVELENGTH_RESET = 16'd410;

  localparam logic [1:0] REG_AMP_LIMIT  = 2'd0;
  localparam logic [1:0] REG_WAVELENGTH = 2'd1;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT,
    OP_MUL
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic        cmd;
    logic [25:0] t;
    logic [23:0] absv;
    logic [16:0] mask;
    logic [23:0] ref_flux;
    logic        sel;
    logic        last;
  } pix_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_SNR_DIV,
    ST_AVG_DIV,
    ST_DMR_DIV,
    ST_DMR_SQRT,
    ST_WFR_DIV,
    ST_WFR_SQRT,
    ST_SNR_SQRT,
    ST_SNRQ_DIV,
    ST_FRAC_DIV,
    ST_EFF_A,
    ST_EFF_MUL1,
    ST_EFF_MUL2,
    ST_EMIT
  } back_state_e;

  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

FILE: src/mss_front.sv
// Front end: takes pixel requests, forms the masked value and the SNR selection.
`timescale 1ns / 1ps
module mss_front import mss_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [23:0] pixel_value_i,
  input  logic [16:0]        mask_weight_i,
  input  logic [23:0]        reference_flux_i,
  input  logic               last_i,
  input  logic [15:0]        amp_limit_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output pix_t               entry_o
);

  logic signed [41:0] prod;
  logic [23:0]        absv;
  logic [20:0]        m10;
  logic [39:0]        lim;

  assign prod = pixel_value_i * $signed({1'b0, mask_weight_i});
  assign absv = pixel_value_i[23] ? (24'(~pixel_value_i) + 24'd1) : 24'(pixel_value_i);
  assign m10  = 21'(mask_weight_i) * 21'd10;
  assign lim  = 40'(absv) * 40'(amp_limit_i);

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    entry_o.cmd      = cmd_i;
    entry_o.t        = prod[41:16];  // floor shift
    entry_o.absv     = absv;
    entry_o.mask     = mask_weight_i;
    entry_o.ref_flux = reference_flux_i;
    entry_o.sel      = (m10 > 21'd65536) && ({8'b0, reference_flux_i, 8'b0} > lim);
    entry_o.last     = last_i;
  end

endmodule

FILE: src/mss_fifo.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module mss_fifo import mss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t din_i,
  input  logic pop_i,
  output pix_t dout_o,
  output logic full_o,
  output logic empty_o
);

  pix_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

FILE: src/mss_arith.sv
// Shared iterative unit: restoring divide, integer square root, shift-add multiply.
`timescale 1ns / 1ps
module mss_arith import mss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arith_req_t  req_i,
  input  logic [79:0] opa_i,
  input  logic [47:0] opb_i,
  output logic        done_o,
  output logic [95:0] res_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  arith_op_e         op_q;
  logic [95:0]       acc_q, sh_q;
  logic [48:0]       rem_q;
  logic [47:0]       d_q;

  logic [48:0] div_rem, sq_rem, sq_trial;

  assign done_o = done_q;
  assign res_o  = acc_q;

  assign div_rem  = {rem_q[47:0], sh_q[79]};
  assign sq_rem   = {rem_q[46:0], sh_q[63:62]};
  assign sq_trial = {acc_q[46:0], 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        unique case (req_i.op)
          OP_DIV:  cnt_q <= DIV_STEPS;
          OP_SQRT: cnt_q <= SQRT_STEPS;
          OP_MUL:  cnt_q <= MUL_STEPS;
          default: cnt_q <= DIV_STEPS;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      acc_q <= '0;
      rem_q <= '0;
      unique case (req_i.op)
        OP_DIV: begin
          sh_q <= {16'b0, opa_i};
          d_q  <= opb_i;
        end
        OP_SQRT: begin
          sh_q <= {32'b0, opa_i[63:0]};
          d_q  <= opb_i;
        end
        OP_MUL: begin
          sh_q <= {16'b0, opa_i};
          d_q  <= opb_i;
        end
        default: begin
          sh_q <= '0;
          d_q  <= '0;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        OP_DIV: begin
          if (div_rem >= {1'b0, d_q}) begin
            rem_q <= div_rem - {1'b0, d_q};
            acc_q <= {acc_q[94:0], 1'b1};
          end else begin
            rem_q <= div_rem;
            acc_q <= {acc_q[94:0], 1'b0};
          end
          sh_q <= {sh_q[94:0], 1'b0};
        end
        OP_SQRT: begin
          if (sq_rem >= sq_trial) begin
            rem_q <= sq_rem - sq_trial;
            acc_q <= {acc_q[94:0], 1'b1};
          end else begin
            rem_q <= sq_rem;
            acc_q <= {acc_q[94:0], 1'b0};
          end
          sh_q <= {sh_q[93:0], 2'b00};
        end
        OP_MUL: begin
          if (d_q[0]) begin
            acc_q <= acc_q + sh_q;
          end
          sh_q <= {sh_q[94:0], 1'b0};
          d_q  <= {1'b0, d_q[47:1]};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

endmodule

FILE: src/mss_back.sv
// Back end: masked accumulators and the end-of-mode result sequencer.
`timescale 1ns / 1ps
module mss_back import mss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  pix_t               fifo_data_i,
  output logic               pop_o,
  input  logic [15:0]        wavelength_i,
  output arith_req_t         arith_req_o,
  output logic [79:0]        arith_opa_o,
  output logic [47:0]        arith_opb_o,
  input  logic               arith_done_i,
  input  logic [95:0]        arith_res_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         mode_index_o,
  output logic signed [23:0] dm_average_o,
  output logic [22:0]        dm_rms_o,
  output logic [22:0]        wfs_rms_o,
  output logic [31:0]        snr_o,
  output logic [16:0]        flux_fraction_o,
  output logic [47:0]        efficiency_o
);

  back_state_e state_q, state_d;
  pix_t        it_q;
  logic        issued_q;

  logic [47:0]       dm_sum_q;
  logic [63:0]       dm_sq_q, wfs_sq_q, snr_sq_q;
  logic [31:0]       dm_w_q, wfs_w_q;
  logic [39:0]       ref_tot_q, used_q;
  logic [MODE_W-1:0] mode_cnt_q;

  logic [23:0] avg_q;
  logic [22:0] dm_rms_q, wfs_rms_q;
  logic [31:0] snr_q, sr_q;
  logic [16:0] frac_q;
  logic [47:0] eff_q, a_q;
  logic [40:0] b_q;
  logic [63:0] x_q;

  logic        out_valid_q;
  logic [9:0]  o_idx_q;
  logic [23:0] o_avg_q;
  logic [22:0] o_dmr_q, o_wfr_q;
  logic [31:0] o_snr_q;
  logic [16:0] o_frac_q;
  logic [47:0] o_eff_q;

  logic               is_op, skip, adv;
  logic signed [51:0] tt_s;
  logic [63:0]        tt;
  logic [47:0]        sq_abs, dm_mag;
  logic [23:0]        avg_res, neg_q;
  logic [22:0]        rms_res;
  logic [63:0]        x_res;

  assign tt_s   = $signed(it_q.t) * $signed(it_q.t);
  assign tt     = {12'b0, tt_s};
  assign sq_abs = 48'(it_q.absv) * 48'(it_q.absv);
  assign dm_mag = dm_sum_q[47] ? (~dm_sum_q + 48'd1) : dm_sum_q;

  always_comb begin
    neg_q   = (arith_res_i[79:0] > 80'd8388608) ? 24'd8388608 : arith_res_i[23:0];
    avg_res = dm_sum_q[47] ? (24'd0 - neg_q)
                           : ((arith_res_i[79:0] > 80'd8388607) ? 24'd8388607
                                                                 : arith_res_i[23:0]);
    rms_res = (arith_res_i[31:0] > 32'd8388607) ? 23'd8388607 : arith_res_i[22:0];
    x_res   = (|arith_res_i[79:64]) ? '1 : arith_res_i[63:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (!fifo_empty_i) state_d = ST_ACC;
      ST_ACC: begin
        if (it_q.cmd && it_q.sel) state_d = ST_SNR_DIV;
        else if (it_q.last)       state_d = ST_AVG_DIV;
        else                      state_d = ST_IDLE;
      end
      ST_SNR_DIV:  if (adv) state_d = it_q.last ? ST_AVG_DIV : ST_IDLE;
      ST_AVG_DIV:  if (adv) state_d = ST_DMR_DIV;
      ST_DMR_DIV:  if (adv) state_d = skip ? ST_WFR_DIV : ST_DMR_SQRT;
      ST_DMR_SQRT: if (adv) state_d = ST_WFR_DIV;
      ST_WFR_DIV:  if (adv) state_d = skip ? ST_SNR_SQRT : ST_WFR_SQRT;
      ST_WFR_SQRT: if (adv) state_d = ST_SNR_SQRT;
      ST_SNR_SQRT: if (adv) state_d = skip ? ST_EFF_A : ST_SNRQ_DIV;
      ST_SNRQ_DIV: if (adv) state_d = ST_FRAC_DIV;
      ST_FRAC_DIV: if (adv) state_d = ST_EFF_A;
      ST_EFF_A:    state_d = ST_EFF_MUL1;
      ST_EFF_MUL1: if (adv) state_d = ST_EFF_MUL2;
      ST_EFF_MUL2: if (adv) state_d = ST_EMIT;
      ST_EMIT:     if (adv) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o          = 1'b0;
    is_op          = 1'b0;
    skip           = 1'b0;
    arith_req_o.op = OP_DIV;
    arith_opa_o    = '0;
    arith_opb_o    = '0;
    unique case (state_q)
      ST_IDLE: pop_o = !fifo_empty_i;
      ST_SNR_DIV: begin
        is_op       = 1'b1;
        arith_opa_o = {16'b0, sq_abs, 16'b0};
        arith_opb_o = {24'b0, it_q.ref_flux};
      end
      ST_AVG_DIV: begin
        is_op       = 1'b1;
        skip        = (dm_w_q == '0);
        arith_opa_o = {16'b0, dm_mag, 16'b0};
        arith_opb_o = {16'b0, dm_w_q};
      end
      ST_DMR_DIV: begin
        is_op       = 1'b1;
        skip        = (dm_w_q == '0);
        arith_opa_o = {dm_sq_q, 16'b0};
        arith_opb_o = {16'b0, dm_w_q};
      end
      ST_WFR_DIV: begin
        is_op       = 1'b1;
        skip        = (wfs_w_q == '0);
        arith_opa_o = {wfs_sq_q, 16'b0};
        arith_opb_o = {16'b0, wfs_w_q};
      end
      ST_DMR_SQRT, ST_WFR_SQRT: begin
        is_op          = 1'b1;
        arith_req_o.op = OP_SQRT;
        arith_opa_o    = {16'b0, x_q};
      end
      ST_SNR_SQRT: begin
        is_op          = 1'b1;
        skip           = (ref_tot_q == '0);
        arith_req_o.op = OP_SQRT;
        arith_opa_o    = {16'b0, snr_sq_q};
      end
      ST_SNRQ_DIV: begin
        is_op       = 1'b1;
        arith_opa_o = {32'b0, sr_q, 16'b0};
        arith_opb_o = {8'b0, ref_tot_q};
      end
      ST_FRAC_DIV: begin
        is_op       = 1'b1;
        arith_opa_o = {24'b0, used_q, 16'b0};
        arith_opb_o = {8'b0, ref_tot_q};
      end
      ST_EFF_MUL1: begin
        is_op          = 1'b1;
        arith_req_o.op = OP_MUL;
        arith_opa_o    = {32'b0, a_q};
        arith_opb_o    = EFF_K;
      end
      ST_EFF_MUL2: begin
        is_op          = 1'b1;
        arith_req_o.op = OP_MUL;
        arith_opa_o    = {32'b0, a_q};
        arith_opb_o    = {7'b0, b_q};
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    arith_req_o.start = is_op && !issued_q && !skip;
    if (state_q == ST_EMIT) adv = !out_valid_q || !out_stall_i;
    else                    adv = is_op && (skip || (issued_q && arith_done_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dm_sum_q    <= '0;
      dm_sq_q     <= '0;
      dm_w_q      <= '0;
      wfs_sq_q    <= '0;
      wfs_w_q     <= '0;
      ref_tot_q   <= '0;
      snr_sq_q    <= '0;
      used_q      <= '0;
      mode_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (arith_req_o.start)  issued_q <= 1'b1;
      else if (arith_done_i)  issued_q <= 1'b0;

      if (state_q == ST_EMIT && adv) out_valid_q <= 1'b1;
      else if (!out_stall_i)         out_valid_q <= 1'b0;

      if (state_q == ST_ACC) begin
        if (!it_q.cmd) begin
          dm_sum_q <= dm_sum_q + {{22{it_q.t[25]}}, it_q.t};
          dm_sq_q  <= add_sat64(dm_sq_q, tt);
          dm_w_q   <= dm_w_q + 32'(it_q.mask);
        end else begin
          wfs_sq_q  <= add_sat64(wfs_sq_q, tt);
          wfs_w_q   <= wfs_w_q + 32'(it_q.mask);
          ref_tot_q <= ref_tot_q + 40'(it_q.ref_flux);
        end
      end
      if (state_q == ST_SNR_DIV && adv) begin
        snr_sq_q <= add_sat64(snr_sq_q, arith_res_i[63:0]);
        used_q   <= used_q + 40'(it_q.ref_flux);
      end
      if (state_q == ST_EMIT && adv) begin
        dm_sum_q   <= '0;
        dm_sq_q    <= '0;
        dm_w_q     <= '0;
        wfs_sq_q   <= '0;
        wfs_w_q    <= '0;
        ref_tot_q  <= '0;
        snr_sq_q   <= '0;
        used_q     <= '0;
        mode_cnt_q <= (mode_cnt_q == MODE_W'(MAX_MODES-1)) ? '0 : mode_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:     if (!fifo_empty_i) it_q <= fifo_data_i;
      ST_AVG_DIV:  if (skip) avg_q <= '0; else if (adv) avg_q <= avg_res;
      ST_DMR_DIV:  if (skip) dm_rms_q <= '0; else if (adv) x_q <= x_res;
      ST_DMR_SQRT: if (adv) dm_rms_q <= rms_res;
      ST_WFR_DIV:  if (skip) wfs_rms_q <= '0; else if (adv) x_q <= x_res;
      ST_WFR_SQRT: if (adv) wfs_rms_q <= rms_res;
      ST_SNR_SQRT: begin
        if (skip) begin
          snr_q  <= '0;
          frac_q <= '0;
        end else if (adv) begin
          sr_q <= arith_res_i[31:0];
        end
      end
      ST_SNRQ_DIV: if (adv) snr_q <= (|arith_res_i[79:32]) ? '1 : arith_res_i[31:0];
      ST_FRAC_DIV: begin
        if (adv) frac_q <= (arith_res_i[79:0] > 80'd65536) ? 17'd65536 : arith_res_i[16:0];
      end
      ST_EFF_A:    a_q <= 48'(wavelength_i) * 48'(snr_q);
      ST_EFF_MUL1: if (adv) b_q <= arith_res_i[72:32];
      ST_EFF_MUL2: if (adv) eff_q <= (|arith_res_i[95:80]) ? '1 : arith_res_i[79:32];
      ST_EMIT: begin
        if (adv) begin
          o_idx_q  <= mode_cnt_q;
          o_avg_q  <= avg_q;
          o_dmr_q  <= dm_rms_q;
          o_wfr_q  <= wfs_rms_q;
          o_snr_q  <= snr_q;
          o_frac_q <= frac_q;
          o_eff_q  <= eff_q;
        end
      end
      default: begin
        it_q <= it_q;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign mode_index_o    = o_idx_q;
  assign dm_average_o    = o_avg_q;
  assign dm_rms_o        = o_dmr_q;
  assign wfs_rms_o       = o_wfr_q;
  assign snr_o           = o_snr_q;
  assign flux_fraction_o = o_frac_q;
  assign efficiency_o    = o_eff_q;

endmodule

FILE: src/mode_sensitivity_statistics.sv
// Mode sensitivity statistics: top level with configuration registers.
// Usage:
//   Pixel requests enter on in_valid_i/in_stall_o; each carries a DM or WFS pixel of
//   the current mode. The request flagged last closes the mode and yields one result
//   on out_valid_o/out_stall_i: mean and RMS of the DM mode, RMS of the WFS response,
//   SNR, used flux fraction and photon efficiency.
//   cfg_valid_i/cfg_ready_o write amp_limit (index 0) and wavelength (index 1); write
//   them only while no mode is in flight. Other indexes are ignored.
// Timing:
//   A four-entry queue holds pixels between the front end and the back end. The back
//   end takes each pixel through an idle and an accumulate step; a WFS pixel that passes the
//   SNR selection also waits on the 80-step divider in the shared iterative unit.
//   Closing a mode runs up to five divides, three square roots and two multiplies one
//   after another on that unit; a zero weight or zero flux total skips some of them.
//   Results sit in an output register; while the receiver stalls the back end waits
//   in its final step, and the queue keeps taking pixels until it is full.
// Reset clears all sums, the mode counter and the output valid, and loads the
//   register defaults (amp_limit 1.0, wavelength 1.6 um).
`timescale 1ns / 1ps
module mode_sensitivity_statistics import mss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [23:0] pixel_value_i,
  input  logic [16:0]        mask_weight_i,
  input  logic [23:0]        reference_flux_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         mode_index_o,
  output logic signed [23:0] dm_average_o,
  output logic [22:0]        dm_rms_o,
  output logic [22:0]        wfs_rms_o,
  output logic [31:0]        snr_o,
  output logic [16:0]        flux_fraction_o,
  output logic [47:0]        efficiency_o
);

  logic [15:0] amp_limit_q, wavelength_q;
  logic        push, pop, fifo_full, fifo_empty, arith_done;
  pix_t        entry, head;
  arith_req_t  arith_req;
  logic [79:0] arith_opa;
  logic [47:0] arith_opb;
  logic [95:0] arith_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_limit_q  <= AMP_LIMIT_RESET;
      wavelength_q <= WAVELENGTH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AMP_LIMIT:  amp_limit_q  <= cfg_data_i;
        REG_WAVELENGTH: wavelength_q <= cfg_data_i;
        default:        amp_limit_q  <= amp_limit_q;
      endcase
    end
  end

  mss_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .pixel_value_i    (pixel_value_i),
    .mask_weight_i    (mask_weight_i),
    .reference_flux_i (reference_flux_i),
    .last_i           (last_i),
    .amp_limit_i      (amp_limit_q),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .entry_o          (entry)
  );

  mss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (entry),
    .pop_i   (pop),
    .dout_o  (head),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  mss_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .opa_i  (arith_opa),
    .opb_i  (arith_opb),
    .done_o (arith_done),
    .res_o  (arith_res)
  );

  mss_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (fifo_empty),
    .fifo_data_i     (head),
    .pop_o           (pop),
    .wavelength_i    (wavelength_q),
    .arith_req_o     (arith_req),
    .arith_opa_o     (arith_opa),
    .arith_opb_o     (arith_opb),
    .arith_done_i    (arith_done),
    .arith_res_i     (arith_res),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_index_o    (mode_index_o),
    .dm_average_o    (dm_average_o),
    .dm_rms_o        (dm_rms_o),
    .wfs_rms_o       (wfs_rms_o),
    .snr_o           (snr_o),
    .flux_fraction_o (flux_fraction_o),
    .efficiency_o    (efficiency_o)
  );

endmodule

FILE: src/mss_checker.sv
// Port-level checks for the mode sensitivity statistics block, bound to the top level.
`timescale 1ns / 1ps
module mss_checker import mss_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  mode_index_o,
  input logic [31:0] snr_o,
  input logic [16:0] flux_fraction_o,
  input logic [47:0] efficiency_o
);

  logic [MODE_W-1:0] exp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_idx_q <= (exp_idx_q == MODE_W'(MAX_MODES-1)) ? '0 : exp_idx_q + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_index_o) && $stable(snr_o))
    else $error("stalled result changed");

  a_mode_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_index_o == exp_idx_q)
    else $error("mode index out of sequence");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flux_fraction_o <= 17'd65536)
    else $error("flux fraction above one");

  a_eff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && snr_o == 32'd0 |-> efficiency_o == 48'd0)
    else $error("efficiency nonzero with zero snr");

endmodule

bind mode_sensitivity_statistics mss_checker u_mss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .mode_index_o    (mode_index_o),
  .snr_o           (snr_o),
  .flux_fraction_o (flux_fraction_o),
  .efficiency_o    (efficiency_o)
);
